// File: sv/dalf_pkg.sv
// ============================================================================
// dalf_pkg
// Shared types and constants for the dual additive lagged Fibonacci generator.
// ============================================================================
`default_nettype none

package dalf_pkg;

    // table geometry and word size
    localparam int TABLE_LEN   = 55;
    localparam int LAG_SHORT   = 24;
    localparam int PARTNER_OFS = TABLE_LEN - LAG_SHORT;
    localparam int IDX_W       = 6;
    localparam int WORD_W      = 32;
    localparam int NUM_TABLES  = 2;

    // result buffer
    localparam int OUT_DEPTH   = 3;
    localparam int OUT_PTR_W   = 2;
    localparam int OUT_CNT_W   = 2;

    // request codes
    typedef enum logic [1:0] {
        REQ_SEED_FIRST  = 2'd0,
        REQ_SEED_SECOND = 2'd1,
        REQ_FINISH      = 2'd2,
        REQ_GENERATE    = 2'd3
    } t_req;

    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [WORD_W-1:0] t_word;

endpackage

`default_nettype wire

// File: sv/dual_additive_lagged_fibonacci_rng.sv
// ============================================================================
// dual_additive_lagged_fibonacci_rng
// Two 55-word additive lagged Fibonacci generators (lags 24/55, mod 2^32)
// sharing one ring position; generate returns the XOR of both new words.
// ============================================================================
// Usage:
//   Input channel (i_valid / o_stall) carries a request: seed the first or
//   second table at i_seed_index, finish seeding, or generate. A transaction
//   completes on a rising edge with i_valid high and o_stall low.
//   Output channel (o_valid / i_stall) carries o_random_word, one per
//   generate request, in request order; other requests give no result.
// Throughput: one request per cycle, sustained while o_stall is low.
// Pipeline: a request is registered into stage 1 with its memory reads, and a
//   generate word enters the result buffer at write-back. Each table lives in a
//   memory with one write and two registered reads per cycle; one-deep
//   forwarding of each table's last write covers the read-to-write-back loop.
// Stall: results queue in a 3-entry buffer; o_stall rises when the buffer
//   count plus a generate in the write-back stage reaches the buffer depth,
//   so with i_stall low the input never stalls.
// Reset: ring position, odd flags, buffer and pipeline valid clear at once;
//   the tables are undefined until seeded, and no clearing pass is run.
// ============================================================================
`default_nettype none

module dual_additive_lagged_fibonacci_rng (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [5:0]  i_seed_index,
    input  wire logic [31:0] i_seed_word,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_random_word
);

    // ------------------------------------------------------------------
    // stage 0: request decode and read address generation
    // ------------------------------------------------------------------
    dalf_pkg::t_req  w_req;
    logic            w_in_acc;
    logic            w_idx_ok;
    dalf_pkg::t_idx  w_addr;
    dalf_pkg::t_idx  w_partner;
    logic [dalf_pkg::IDX_W:0] w_partner_sum;

    dalf_pkg::t_idx  r_pos;
    dalf_pkg::t_idx  n_pos;

    assign w_req    = dalf_pkg::t_req'(i_req_type);
    assign w_in_acc = i_valid && !o_stall;
    assign w_idx_ok = i_seed_index < dalf_pkg::IDX_W'(dalf_pkg::TABLE_LEN);

    // partner entry (pos + 31) mod 55
    assign w_partner_sum = {1'b0, r_pos} + (dalf_pkg::IDX_W+1)'(dalf_pkg::PARTNER_OFS);
    assign w_partner = (w_partner_sum >= (dalf_pkg::IDX_W+1)'(dalf_pkg::TABLE_LEN))
        ? dalf_pkg::IDX_W'(w_partner_sum - (dalf_pkg::IDX_W+1)'(dalf_pkg::TABLE_LEN))
        : dalf_pkg::IDX_W'(w_partner_sum);

    // entry that the request modifies
    always_comb begin
        case (w_req)
            dalf_pkg::REQ_SEED_FIRST,
            dalf_pkg::REQ_SEED_SECOND: w_addr = w_idx_ok ? i_seed_index : '0;
            dalf_pkg::REQ_FINISH:      w_addr = '0;
            dalf_pkg::REQ_GENERATE:    w_addr = r_pos;
            default:                   w_addr = '0;
        endcase
    end

    // ring position
    always_comb begin
        n_pos = r_pos;
        if (w_in_acc) begin
            case (w_req)
                dalf_pkg::REQ_FINISH:   n_pos = '0;
                dalf_pkg::REQ_GENERATE: n_pos =
                    (r_pos == dalf_pkg::IDX_W'(dalf_pkg::TABLE_LEN - 1)) ? '0 : r_pos + 1'b1;
                default:                n_pos = r_pos;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

    // ------------------------------------------------------------------
    // stage 1 registers: request carried alongside the memory reads
    // ------------------------------------------------------------------
    logic            r_s1_valid;
    dalf_pkg::t_req  r_s1_req;
    logic            r_s1_idx_ok;
    dalf_pkg::t_idx  r_s1_addr;
    dalf_pkg::t_idx  r_s1_partner;
    dalf_pkg::t_word r_s1_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_req     <= w_req;
            r_s1_idx_ok  <= w_idx_ok;
            r_s1_addr    <= w_addr;
            r_s1_partner <= w_partner;
            r_s1_word    <= i_seed_word;
        end
    end

    logic w_s1_gen;
    logic w_s1_fin;
    assign w_s1_gen = r_s1_valid && (r_s1_req == dalf_pkg::REQ_GENERATE);
    assign w_s1_fin = r_s1_valid && (r_s1_req == dalf_pkg::REQ_FINISH);

    // ------------------------------------------------------------------
    // per-table memory, forwarding and write-back
    // ------------------------------------------------------------------
    dalf_pkg::t_word w_new [dalf_pkg::NUM_TABLES];

    for (genvar t = 0; t < dalf_pkg::NUM_TABLES; t++) begin : g_tab
        dalf_pkg::t_word r_mem [0:dalf_pkg::TABLE_LEN-1];
        dalf_pkg::t_word r_rd_a;
        dalf_pkg::t_word r_rd_b;
        logic            r_fw_en;
        dalf_pkg::t_idx  r_fw_addr;
        dalf_pkg::t_word r_fw_data;
        logic            r_odd;
        dalf_pkg::t_word w_a;
        dalf_pkg::t_word w_b;
        logic            w_seed_me;
        logic            w_we;
        dalf_pkg::t_word w_wdata;
        logic            n_odd;

        // registered reads: entry to modify and its lag partner
        always_ff @(posedge i_clk) begin
            if (w_in_acc) begin
                r_rd_a <= r_mem[w_addr];
                r_rd_b <= r_mem[w_partner];
            end
        end

        // last write bypasses a read issued at the same edge
        assign w_a = (r_fw_en && r_fw_addr == r_s1_addr)    ? r_fw_data : r_rd_a;
        assign w_b = (r_fw_en && r_fw_addr == r_s1_partner) ? r_fw_data : r_rd_b;

        assign w_seed_me = r_s1_valid && r_s1_idx_ok &&
            (r_s1_req == ((t == 0) ? dalf_pkg::REQ_SEED_FIRST : dalf_pkg::REQ_SEED_SECOND));

        // write-back data and enable
        always_comb begin
            w_we    = 1'b0;
            w_wdata = w_a + w_b;
            n_odd   = r_odd;
            if (w_seed_me) begin
                w_we    = 1'b1;
                w_wdata = r_s1_word;
                n_odd   = r_odd | r_s1_word[0];
            end else if (w_s1_fin) begin
                w_we    = !r_odd;
                w_wdata = w_a | dalf_pkg::WORD_W'(1);
                n_odd   = 1'b0;
            end else if (w_s1_gen) begin
                w_we    = 1'b1;
                w_wdata = w_a + w_b;
            end
        end

        assign w_new[t] = w_wdata;

        always_ff @(posedge i_clk) begin
            if (w_we) begin
                r_mem[r_s1_addr] <= w_wdata;
            end
        end

        // forwarding register and odd flag
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_fw_en <= 1'b0;
                r_odd   <= 1'b0;
            end else begin
                r_odd <= n_odd;
                if (w_we) begin
                    r_fw_en <= 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_we) begin
                r_fw_addr <= r_s1_addr;
                r_fw_data <= w_wdata;
            end
        end
    end

    // ------------------------------------------------------------------
    // result buffer
    // ------------------------------------------------------------------
    dalf_pkg::t_word r_buf [dalf_pkg::OUT_DEPTH];
    logic [dalf_pkg::OUT_PTR_W-1:0] r_wr_ptr;
    logic [dalf_pkg::OUT_PTR_W-1:0] r_rd_ptr;
    logic [dalf_pkg::OUT_CNT_W-1:0] r_count;
    logic [dalf_pkg::OUT_CNT_W-1:0] n_count;
    logic                           w_push;
    logic                           w_pop;
    logic [dalf_pkg::OUT_CNT_W:0]   w_load;

    assign w_push = w_s1_gen;
    assign w_pop  = o_valid && !i_stall;

    always_comb begin
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (!w_push && w_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == dalf_pkg::OUT_PTR_W'(dalf_pkg::OUT_DEPTH - 1))
                    ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == dalf_pkg::OUT_PTR_W'(dalf_pkg::OUT_DEPTH - 1))
                    ? '0 : r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wr_ptr] <= w_new[0] ^ w_new[1];
        end
    end

    // input stalls when the buffer, counting a generate in write-back, is full
    assign w_load        = {1'b0, r_count} + (dalf_pkg::OUT_CNT_W+1)'(w_s1_gen);
    assign o_stall       = w_load >= (dalf_pkg::OUT_CNT_W+1)'(dalf_pkg::OUT_DEPTH);
    assign o_valid       = r_count != '0;
    assign o_random_word = r_buf[r_rd_ptr];

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos < dalf_pkg::IDX_W'(dalf_pkg::TABLE_LEN))
        else $error("ring position out of range");

    a_room_for_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (r_count < dalf_pkg::OUT_CNT_W'(dalf_pkg::OUT_DEPTH) || w_pop))
        else $error("result buffer overflow");

    a_gen_reaches_stage1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_req == dalf_pkg::REQ_GENERATE) |=> w_s1_gen)
        else $error("generate request lost before write-back");

    a_count_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_push && !w_pop) |=> $stable(r_count))
        else $error("result count changed without push or pop");

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Self-checking bench for the dual additive lagged Fibonacci generator: a
// queue-fed driver issues seed, finish and generate requests with random
// gaps, a monitor tracks both tables and the ring position to predict each
// random word, and the output side stalls at random while results are checked.
// ============================================================================

module tb_top;

    typedef struct {
        dalf_pkg::t_req  kind;
        dalf_pkg::t_idx  idx;
        dalf_pkg::t_word word;
    } t_request;

    // dut ports
    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_valid      = 1'b0;
    logic        o_stall;
    logic [1:0]  i_req_type   = dalf_pkg::REQ_SEED_FIRST;
    logic [5:0]  i_seed_index = '0;
    logic [31:0] i_seed_word  = '0;
    logic        o_valid;
    logic        i_stall      = 1'b0;
    logic [31:0] o_random_word;

    // stimulus and scoreboard
    t_request                     pending_requests[$];
    dalf_pkg::t_word              expected_words[$];
    int                           total_requests = 0;
    int                           planned_count  = 0;
    int                           accepted_count = 0;
    int                           error_count    = 0;
    bit [dalf_pkg::TABLE_LEN-1:0] written_first  = '0;
    bit [dalf_pkg::TABLE_LEN-1:0] written_second = '0;

    // predicted generator state
    dalf_pkg::t_word        lfg_first  [dalf_pkg::TABLE_LEN];
    dalf_pkg::t_word        lfg_second [dalf_pkg::TABLE_LEN];
    dalf_pkg::t_idx         ring_pos   = '0;
    bit                     odd_first  = 1'b0;
    bit                     odd_second = 1'b0;

    // handshake bookkeeping
    bit                     in_taken  = 1'b0;
    bit                     out_taken = 1'b0;
    int                     send_gap  = 0;
    int                     hold_left = 0;
    int                     calm_left [2] = '{0, 0};
    t_request               next_req;

    dual_additive_lagged_fibonacci_rng dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_req_type    (i_req_type),
        .i_seed_index  (i_seed_index),
        .i_seed_word   (i_seed_word),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_random_word (o_random_word)
    );

    // clock
    always #5 i_clk = ~i_clk;

    // wait cycles per transaction, with occasional stretches of none
    function automatic int draw_wait(int side);
        if (calm_left[side] > 0) begin
            calm_left[side]--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0)
            calm_left[side] = $urandom_range(10, 40);
        return $urandom_range(0, 4);
    endfunction

    // queue one request and track which entries hold defined words
    task automatic add_request(dalf_pkg::t_req kind, int idx, dalf_pkg::t_word word);
        t_request r;
        r.kind = kind;
        r.idx  = dalf_pkg::t_idx'(idx);
        r.word = word;
        pending_requests.push_back(r);
        if (kind == dalf_pkg::REQ_SEED_FIRST || kind == dalf_pkg::REQ_SEED_SECOND) begin
            if (idx < dalf_pkg::TABLE_LEN) begin
                if (kind == dalf_pkg::REQ_SEED_FIRST)
                    written_first[idx] = 1'b1;
                else
                    written_second[idx] = 1'b1;
                planned_count++;
            end
        end else begin
            planned_count++;
        end
    endtask

    // one table entry; modes 2 and 3 keep bit 0 clear, mode 3 hides an odd word
    task automatic seed_entry(dalf_pkg::t_req kind, int idx, int mode, bit odd_slot);
        dalf_pkg::t_word w;
        w = $urandom();
        if (mode == 2) begin
            w[0] = 1'b0;
        end else if (mode == 3) begin
            if (odd_slot)
                add_request(kind, idx, w | 32'h1);
            w[0] = 1'b0;
        end
        add_request(kind, idx, w);
    endtask

    // full seeding of both tables, some noise, usually closed by finish
    task automatic seed_session();
        int mode_first;
        int mode_second;
        int odd_at;
        int n;
        bit descending;
        dalf_pkg::t_req seed_kind;
        mode_first  = $urandom_range(0, 3);
        mode_second = $urandom_range(0, 3);
        odd_at      = $urandom_range(0, dalf_pkg::TABLE_LEN - 1);
        descending  = $urandom_range(0, 1);
        for (int i = 0; i < dalf_pkg::TABLE_LEN; i++) begin
            n = descending ? dalf_pkg::TABLE_LEN - 1 - i : i;
            seed_entry(dalf_pkg::REQ_SEED_FIRST, n, mode_first, n == odd_at);
            seed_entry(dalf_pkg::REQ_SEED_SECOND, n, mode_second, n == odd_at);
            if ($urandom_range(0, 19) == 0) begin
                seed_kind = ($urandom_range(0, 1) == 0) ? dalf_pkg::REQ_SEED_FIRST
                                                        : dalf_pkg::REQ_SEED_SECOND;
                add_request(seed_kind, $urandom_range(dalf_pkg::TABLE_LEN, 63), $urandom());
            end
        end
        if ($urandom_range(0, 7) != 0)
            add_request(dalf_pkg::REQ_FINISH, $urandom_range(0, 63), $urandom());
    endtask

    // mostly generates, with stray seeds, ignored seeds and finishes
    task automatic generate_burst();
        int len;
        int pick;
        dalf_pkg::t_req seed_kind;
        len = $urandom_range(10, 70);
        for (int i = 0; i < len; i++) begin
            pick      = $urandom_range(0, 19);
            seed_kind = ($urandom_range(0, 1) == 0) ? dalf_pkg::REQ_SEED_FIRST
                                                    : dalf_pkg::REQ_SEED_SECOND;
            if (pick == 0)
                add_request(seed_kind, $urandom_range(0, dalf_pkg::TABLE_LEN - 1), $urandom());
            else if (pick == 1)
                add_request(seed_kind, $urandom_range(dalf_pkg::TABLE_LEN, 63), $urandom());
            else if (pick == 2)
                add_request(dalf_pkg::REQ_FINISH, $urandom_range(0, 63), $urandom());
            else
                add_request(dalf_pkg::REQ_GENERATE, $urandom_range(0, 63), $urandom());
        end
    endtask

    // predictor: update tables for one accepted request
    task automatic apply_request(dalf_pkg::t_req kind, dalf_pkg::t_idx idx,
                                 dalf_pkg::t_word word);
        int partner;
        case (kind)
            dalf_pkg::REQ_SEED_FIRST: begin
                if (idx < dalf_pkg::TABLE_LEN) begin
                    lfg_first[idx] = word;
                    if (word[0])
                        odd_first = 1'b1;
                end
            end
            dalf_pkg::REQ_SEED_SECOND: begin
                if (idx < dalf_pkg::TABLE_LEN) begin
                    lfg_second[idx] = word;
                    if (word[0])
                        odd_second = 1'b1;
                end
            end
            dalf_pkg::REQ_FINISH: begin
                ring_pos = '0;
                if (!odd_first)
                    lfg_first[0][0] = 1'b1;
                if (!odd_second)
                    lfg_second[0][0] = 1'b1;
                odd_first  = 1'b0;
                odd_second = 1'b0;
            end
            dalf_pkg::REQ_GENERATE: begin
                partner = ring_pos + dalf_pkg::PARTNER_OFS;
                if (partner >= dalf_pkg::TABLE_LEN)
                    partner -= dalf_pkg::TABLE_LEN;
                lfg_first[ring_pos]  = lfg_first[ring_pos] + lfg_first[partner];
                lfg_second[ring_pos] = lfg_second[ring_pos] + lfg_second[partner];
                expected_words.push_back(lfg_first[ring_pos] ^ lfg_second[ring_pos]);
                ring_pos = (ring_pos == dalf_pkg::TABLE_LEN - 1) ? '0 : ring_pos + 1'b1;
            end
            default: ;
        endcase
    endtask

    task automatic note_error(string msg);
        error_count++;
        if (error_count <= 10)
            $display("%0t: %s", $realtime, msg);
    endtask

    // request driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || in_taken) begin
                if (send_gap > 0) begin
                    i_valid <= 1'b0;
                    send_gap--;
                end else if (pending_requests.size() != 0) begin
                    next_req = pending_requests.pop_front();
                    i_valid      <= 1'b1;
                    i_req_type   <= next_req.kind;
                    i_seed_index <= next_req.idx;
                    i_seed_word  <= next_req.word;
                    send_gap = draw_wait(0);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // result stall generator
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (out_taken)
                hold_left = draw_wait(1);
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // monitor: check results, then predict from accepted requests
    always @(posedge i_clk) begin
        in_taken  <= i_rst_n && i_valid && !o_stall;
        out_taken <= i_rst_n && o_valid && !i_stall;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_words.size() == 0)
                note_error($sformatf("unexpected random_word %h, none pending", o_random_word));
            else if (o_random_word !== expected_words[0])
                note_error($sformatf("random_word mismatch: expected %h, got %h",
                                     expected_words[0], o_random_word));
            if (expected_words.size() != 0)
                void'(expected_words.pop_front());
        end
        if (i_rst_n && i_valid && !o_stall) begin
            apply_request(dalf_pkg::t_req'(i_req_type), i_seed_index, i_seed_word);
            accepted_count++;
        end
    end

    // stimulus, reset and end of test
    initial begin
        // directed: field extremes, ignored indexes, odd tracking, finish cases
        add_request(dalf_pkg::REQ_SEED_FIRST, 0, 32'h0000_0000);
        add_request(dalf_pkg::REQ_SEED_SECOND, 0, 32'hffff_ffff);
        add_request(dalf_pkg::REQ_SEED_FIRST, dalf_pkg::TABLE_LEN, 32'h0000_0001);
        add_request(dalf_pkg::REQ_SEED_FIRST, 63, 32'hffff_ffff);
        add_request(dalf_pkg::REQ_SEED_SECOND, 63, 32'h0000_0001);
        add_request(dalf_pkg::REQ_FINISH, 63, 32'hffff_ffff);
        add_request(dalf_pkg::REQ_SEED_FIRST, dalf_pkg::TABLE_LEN - 1, 32'hffff_ffff);
        add_request(dalf_pkg::REQ_SEED_FIRST, dalf_pkg::TABLE_LEN - 1, 32'hffff_fffe);
        add_request(dalf_pkg::REQ_SEED_SECOND, dalf_pkg::TABLE_LEN - 1, 32'h0000_0000);
        add_request(dalf_pkg::REQ_SEED_SECOND, 32, 32'h8000_0000);
        add_request(dalf_pkg::REQ_FINISH, 0, 32'h0000_0000);
        add_request(dalf_pkg::REQ_FINISH, 21, 32'h5555_aaaa);

        // random: seeding sessions and generate bursts
        while (planned_count < 900) begin
            if (written_first != '1 || written_second != '1 || $urandom_range(0, 5) == 0)
                seed_session();
            else
                generate_burst();
        end
        total_requests = pending_requests.size();

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_count < total_requests)
            @(posedge i_clk);
        while (expected_words.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (error_count == 0 && expected_words.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // watchdog
    initial begin
        #3_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

// File: filelist.f
sv/dalf_pkg.sv
sv/dual_additive_lagged_fibonacci_rng.sv
tb/tb_top.sv
